// ----- hdl/l2s_pkg.sv -----
// Shared constants for the linear-index-to-subscript converter.
// No dependencies; used by the top level.
package l2s_pkg;

   localparam int unsigned CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_LAYOUT      = 2'd0,
      REG_SIZE_FIRST  = 2'd1,
      REG_SIZE_SECOND = 2'd2,
      REG_SIZE_THIRD  = 2'd3
   } reg_index_type;

   typedef enum logic {
      LAYOUT_X_FAST = 1'b0,
      LAYOUT_T_FAST = 1'b1
   } layout_type;

endpackage

// ----- hdl/l2s_if.sv -----
// Valid/ready channel interfaces for index items and coordinate items.
// Depends on nothing.
interface l2s_req_if #(parameter int unsigned INDEX_BITS = 40);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] flat_index;
   modport source (output valid, output flat_index, input ready);
   modport sink (input valid, input flat_index, output ready);
endinterface

interface l2s_rsp_if #(parameter int unsigned INDEX_BITS = 40);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] coord_x;
   logic [INDEX_BITS-1:0] coord_y;
   logic [INDEX_BITS-1:0] coord_z;
   logic [INDEX_BITS-1:0] coord_t;
   modport source (output valid, output coord_x, output coord_y, output coord_z,
                   output coord_t, input ready);
   modport sink (input valid, input coord_x, input coord_y, input coord_z,
                 input coord_t, output ready);
endinterface

// ----- hdl/linear_to_subscript_4d.sv -----
// Top level: linear voxel index to 4D coordinates.
// Depends on l2s_pkg, l2s_if.sv and l2s_div_step.
//
//   channel    dir   handshake        payload
//   req_chan   in    valid / ready    flat_index
//   rsp_chan   out   valid / ready    coord_x, coord_y, coord_z, coord_t
//   csr_*      in    csr_we           csr_index, csr_wdata
//
// Three chained restoring dividers, one
// quotient bit per register stage. One item enters per cycle while the output is not stalled.
// Reset clears the stage valid bits and loads the reset register values.
// A stall at the output freezes every stage; nothing drops or repeats.
module linear_to_subscript_4d #(
   parameter int unsigned INDEX_BITS = 40,
   parameter int unsigned SIZE_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   l2s_req_if.sink                             req_chan,
   l2s_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [l2s_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [SIZE_BITS-1:0]                csr_wdata
);

   localparam int unsigned STAGES = 3 * INDEX_BITS;

   logic                 layout_ff;
   logic [SIZE_BITS-1:0] size_ff [3];
   logic [SIZE_BITS-1:0] eff_size [3];
   logic                 advance;

   logic                  st_valid [STAGES+1];
   logic [INDEX_BITS-1:0] st_quo   [STAGES+1];
   logic [SIZE_BITS-1:0]  st_rem   [STAGES+1];
   logic [SIZE_BITS-1:0]  st_r0    [STAGES+1];
   logic [SIZE_BITS-1:0]  st_r1    [STAGES+1];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff  <= l2s_pkg::LAYOUT_X_FAST;
         size_ff[0] <= SIZE_BITS'(1);
         size_ff[1] <= SIZE_BITS'(1);
         size_ff[2] <= SIZE_BITS'(1);
      end else if (csr_we) begin
         unique case (l2s_pkg::reg_index_type'(csr_index))
            l2s_pkg::REG_LAYOUT:      layout_ff  <= csr_wdata[0];
            l2s_pkg::REG_SIZE_FIRST:  size_ff[0] <= csr_wdata;
            l2s_pkg::REG_SIZE_SECOND: size_ff[1] <= csr_wdata;
            l2s_pkg::REG_SIZE_THIRD:  size_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a size of zero acts as one
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eff_size[i] = (size_ff[i] == '0) ? SIZE_BITS'(1) : size_ff[i];
      end
   end

   // the whole chain moves together; hold it while the output item waits
   assign advance        = rsp_chan.ready || !st_valid[STAGES];
   assign req_chan.ready = advance;

   assign st_valid[0] = req_chan.valid;
   assign st_quo[0]   = req_chan.flat_index;
   assign st_rem[0]   = '0;
   assign st_r0[0]    = '0;
   assign st_r1[0]    = '0;

   // divide by first size, then the quotient by second, then by third
   for (genvar k = 0; k < STAGES; k++) begin : g_step
      l2s_div_step #(
         .INDEX_BITS (INDEX_BITS),
         .SIZE_BITS  (SIZE_BITS),
         .FIRST      ((k % INDEX_BITS) == 0),
         .SLOT       (k / INDEX_BITS)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (st_valid[k]),
         .in_quo    (st_quo[k]),
         .in_rem    (st_rem[k]),
         .in_r0     (st_r0[k]),
         .in_r1     (st_r1[k]),
         .divisor   (eff_size[k / INDEX_BITS]),
         .out_valid (st_valid[k+1]),
         .out_quo   (st_quo[k+1]),
         .out_rem   (st_rem[k+1]),
         .out_r0    (st_r0[k+1]),
         .out_r1    (st_r1[k+1])
      );
   end

   logic [INDEX_BITS-1:0] dig0, dig1, dig2, dig3;

   // digits fastest first; the slowest is the final quotient
   assign dig0 = INDEX_BITS'(st_r0[STAGES]);
   assign dig1 = INDEX_BITS'(st_r1[STAGES]);
   assign dig2 = INDEX_BITS'(st_rem[STAGES]);
   assign dig3 = st_quo[STAGES];

   assign rsp_chan.valid = st_valid[STAGES];

   always_comb begin
      unique case (l2s_pkg::layout_type'(layout_ff))
         l2s_pkg::LAYOUT_X_FAST: begin
            rsp_chan.coord_x = dig0;
            rsp_chan.coord_y = dig1;
            rsp_chan.coord_z = dig2;
            rsp_chan.coord_t = dig3;
         end
         default: begin
            rsp_chan.coord_t = dig0;
            rsp_chan.coord_x = dig1;
            rsp_chan.coord_y = dig2;
            rsp_chan.coord_z = dig3;
         end
      endcase
   end

endmodule

// ----- hdl/l2s_div_step.sv -----
// One registered restoring-division step: retires one quotient bit.
// Depends on nothing; instantiated in a chain by the top level.
module l2s_div_step #(
   parameter int unsigned INDEX_BITS = 40,
   parameter int unsigned SIZE_BITS  = 16,
   parameter bit          FIRST      = 1'b0,
   parameter int unsigned SLOT       = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [INDEX_BITS-1:0] in_quo,
   input  logic [SIZE_BITS-1:0]  in_rem,
   input  logic [SIZE_BITS-1:0]  in_r0,
   input  logic [SIZE_BITS-1:0]  in_r1,
   input  logic [SIZE_BITS-1:0]  divisor,
   output logic                  out_valid,
   output logic [INDEX_BITS-1:0] out_quo,
   output logic [SIZE_BITS-1:0]  out_rem,
   output logic [SIZE_BITS-1:0]  out_r0,
   output logic [SIZE_BITS-1:0]  out_r1
);

   logic                  valid_ff;
   logic [INDEX_BITS-1:0] quo_ff, quo_in;
   logic [SIZE_BITS-1:0]  rem_ff, rem_in, r0_ff, r0_in, r1_ff, r1_in;
   logic [SIZE_BITS-1:0]  rem_base;
   logic [SIZE_BITS:0]    trial, diff;
   logic                  take;

   always_comb begin
      // start a new division from zero remainder, saving the previous one
      rem_base = FIRST ? '0 : in_rem;
      trial    = {rem_base, in_quo[INDEX_BITS-1]};
      diff     = trial - {1'b0, divisor};
      take     = trial >= {1'b0, divisor};
      rem_in   = take ? diff[SIZE_BITS-1:0] : trial[SIZE_BITS-1:0];
      quo_in   = {in_quo[INDEX_BITS-2:0], take};
      r0_in    = (FIRST && SLOT == 1) ? in_rem : in_r0;
      r1_in    = (FIRST && SLOT == 2) ? in_rem : in_r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         r0_ff  <= r0_in;
         r1_ff  <= r1_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_quo   = quo_ff;
   assign out_rem   = rem_ff;
   assign out_r0    = r0_ff;
   assign out_r1    = r1_ff;

endmodule
